@@ rtl/ssr_pkg.sv @@
// Shared types and constants for the step sequencer with judged retries.
// No dependencies; imported by ssr_ctrl and step_sequencer_with_retry.
package ssr_pkg;

  localparam int MaxSteps = 16;
  localparam int StepW    = $clog2(MaxSteps);
  // wide enough for step counts, step indexes plus one and jump targets
  localparam int CmpW     = 6;

  localparam logic RegStepCount = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_ANSWER = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_ACTION      = 3'd0,
    EV_JUDGE       = 3'd1,
    EV_FAIL_ACTION = 3'd2,
    EV_FAIL_JUDGE  = 3'd3,
    EV_DONE_OK     = 3'd4,
    EV_DONE_ERR    = 3'd5
  } ev_e;

  typedef struct packed {
    logic [7:0] fail_code;
    logic [4:0] jump;
    logic [3:0] flags;
  } ctl_t;

  typedef struct packed {
    logic [15:0] finterval;
    logic [7:0]  flimit;
    logic [15:0] interval;
    logic [7:0]  limit;
  } tim_t;

  typedef struct packed {
    logic             valid;
    ev_e              ev;
    logic [3:0]       step;
    logic [7:0]       err;
  } emit_t;

  typedef struct packed {
    logic             re;
    logic [StepW-1:0] addr;
  } rd_t;

endpackage

@@ rtl/ssr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ssr_ctrl.sv @@
// Sequencer control: phase, retry counters, delay counter and the step walk.
// Depends on ssr_pkg; reads the step tables through the rd_o port.
module ssr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssr_pkg::op_e        op_i,
  input  logic                judge_passed_i,
  input  logic [4:0]          step_count_i,
  input  logic                out_free_i,
  output ssr_pkg::rd_t        rd_o,
  input  ssr_pkg::ctl_t       ctl_i,
  input  ssr_pkg::tim_t       tim_i,
  output ssr_pkg::emit_t      emit_o
);
  import ssr_pkg::*;

  typedef enum logic [3:0] {
    ST_IN, ST_RD, ST_RUN, ST_RUN2, ST_ADV, ST_FAILH, ST_FAILH2,
    ST_GIVEUP, ST_DLY, ST_AFTER
  } st_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WJ, PH_DELAY, PH_WFJ, PH_FDELAY
  } ph_e;

  st_e              st_q, st_d, job_q, job_d;
  ph_e              ph_q, ph_d;
  logic [StepW-1:0] cur_q, cur_d;
  logic [7:0]       try_q, try_d, ftry_q, ftry_d;
  logic [15:0]      dly_q, dly_d;

  logic [CmpW-1:0]  n_eff;
  logic             has_next;
  logic             jump_ok;
  logic [15:0]      dly_dec;
  logic [15:0]      iv;
  logic [7:0]       try_inc, ftry_inc;

  always_comb begin
    if (step_count_i == 5'd0) begin
      n_eff = CmpW'(1);
    end else if (CmpW'(step_count_i) > CmpW'(MaxSteps)) begin
      n_eff = CmpW'(MaxSteps);
    end else begin
      n_eff = CmpW'(step_count_i);
    end
  end

  assign has_next = (CmpW'(cur_q) + CmpW'(1)) < n_eff;
  // negative or out-of-range targets mean no jump
  assign jump_ok  = !ctl_i.jump[4] && (CmpW'(ctl_i.jump) < n_eff);
  assign dly_dec  = (dly_q != 16'd0) ? dly_q - 16'd1 : 16'd0;
  assign iv       = (ph_q == PH_WJ) ? tim_i.interval : tim_i.finterval;
  assign try_inc  = (try_q == 8'hFF) ? try_q : try_q + 8'd1;
  assign ftry_inc = (ftry_q == 8'hFF) ? ftry_q : ftry_q + 8'd1;

  assign in_ready_o = (st_q == ST_IN);

  always_comb begin
    st_d   = st_q;
    job_d  = job_q;
    ph_d   = ph_q;
    cur_d  = cur_q;
    try_d  = try_q;
    ftry_d = ftry_q;
    dly_d  = dly_q;
    emit_o = '{valid: 1'b0, ev: EV_ACTION, step: 4'(cur_q), err: 8'd0};
    rd_o   = '{re: 1'b0, addr: cur_q};

    case (st_q)
      ST_IN: begin
        if (in_valid_i) begin
          case (op_i)
            OP_START: begin
              if (ph_q == PH_IDLE) begin
                cur_d  = '0;
                try_d  = 8'd0;
                ftry_d = 8'd0;
                st_d   = ST_RD;
                job_d  = ST_RUN;
              end
            end
            OP_ANSWER: begin
              if (ph_q == PH_WJ || ph_q == PH_WFJ) begin
                if (judge_passed_i) begin
                  st_d = ST_ADV;
                end else begin
                  st_d  = ST_RD;
                  job_d = ST_DLY;
                end
              end
            end
            OP_TICK: begin
              if (ph_q == PH_DELAY || ph_q == PH_FDELAY) begin
                dly_d = dly_dec;
                if (dly_dec == 16'd0) begin
                  st_d  = ST_RD;
                  job_d = ST_AFTER;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rd_o.re = 1'b1;
        st_d    = job_q;
      end
      ST_RUN: begin
        if (out_free_i) begin
          if (ctl_i.flags[0]) begin
            emit_o.valid = 1'b1;
            emit_o.ev    = EV_ACTION;
          end
          st_d = ST_RUN2;
        end
      end
      ST_RUN2, ST_ADV: begin
        if (out_free_i) begin
          if (st_q == ST_RUN2 && ctl_i.flags[1]) begin
            emit_o.valid = 1'b1;
            emit_o.ev    = EV_JUDGE;
            ph_d         = PH_WJ;
            st_d         = ST_IN;
          end else if (has_next) begin
            cur_d  = cur_q + StepW'(1);
            try_d  = 8'd0;
            ftry_d = 8'd0;
            st_d   = ST_RD;
            job_d  = ST_RUN;
          end else begin
            emit_o.valid = 1'b1;
            emit_o.ev    = EV_DONE_OK;
            ph_d         = PH_IDLE;
            st_d         = ST_IN;
          end
        end
      end
      ST_FAILH: begin
        if (out_free_i) begin
          if (!ctl_i.flags[2]) begin
            st_d = ST_GIVEUP;
          end else begin
            emit_o.valid = 1'b1;
            emit_o.ev    = EV_FAIL_ACTION;
            st_d         = ST_FAILH2;
          end
        end
      end
      ST_FAILH2: begin
        if (out_free_i) begin
          if (!ctl_i.flags[3]) begin
            st_d = ST_ADV;
          end else begin
            emit_o.valid = 1'b1;
            emit_o.ev    = EV_FAIL_JUDGE;
            ph_d         = PH_WFJ;
            st_d         = ST_IN;
          end
        end
      end
      ST_GIVEUP: begin
        if (out_free_i) begin
          if (jump_ok) begin
            cur_d  = StepW'(ctl_i.jump[3:0]);
            try_d  = 8'd0;
            ftry_d = 8'd0;
            st_d   = ST_RD;
            job_d  = ST_RUN;
          end else begin
            emit_o.valid = 1'b1;
            emit_o.ev    = EV_DONE_ERR;
            emit_o.err   = ctl_i.fail_code;
            ph_d         = PH_IDLE;
            st_d         = ST_IN;
          end
        end
      end
      ST_DLY: begin
        if (out_free_i) begin
          ph_d  = (ph_q == PH_WJ) ? PH_DELAY : PH_FDELAY;
          dly_d = iv;
          // a zero interval elapses within the same item
          st_d  = (iv == 16'd0) ? ST_AFTER : ST_IN;
        end
      end
      ST_AFTER: begin
        if (out_free_i) begin
          if (ph_q == PH_DELAY) begin
            try_d = try_inc;
            if (try_inc >= tim_i.limit) begin
              st_d = ST_FAILH;
            end else begin
              emit_o.valid = 1'b1;
              emit_o.ev    = EV_JUDGE;
              ph_d         = PH_WJ;
              st_d         = ST_IN;
            end
          end else begin
            ftry_d = ftry_inc;
            if (ftry_inc >= tim_i.flimit) begin
              st_d = ST_GIVEUP;
            end else begin
              emit_o.valid = 1'b1;
              emit_o.ev    = EV_FAIL_JUDGE;
              ph_d         = PH_WFJ;
              st_d         = ST_IN;
            end
          end
        end
      end
      default: begin
        st_d = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IN;
      job_q  <= ST_RUN;
      ph_q   <= PH_IDLE;
      cur_q  <= '0;
      try_q  <= 8'd0;
      ftry_q <= 8'd0;
      dly_q  <= 16'd0;
    end else begin
      st_q   <= st_d;
      job_q  <= job_d;
      ph_q   <= ph_d;
      cur_q  <= cur_d;
      try_q  <= try_d;
      ftry_q <= ftry_d;
      dly_q  <= dly_d;
    end
  end

endmodule

@@ rtl/step_sequencer_with_retry.sv @@
// Top level: APB step_count register, step tables in two RAMs, result register.
// Depends on ssr_pkg, ssr_ram and ssr_ctrl.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   input    | in_valid_i / in_ready_o     | op_i, step_index_i .. judge_passed_i
//   result   | out_valid_o / out_ready_i   | event_res_o, step_number_o,
//            |                             | error_value_o, last_o
//   config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready = 1)
//
// A load, an ignored item or a tick that only counts down is taken without leaving
// the input state. A start visits steps: table read, action, then judge or move on.
// A judge answer or a tick that ends a wait also visits steps, and each visit reads
// the step tables through their registered read port. One item is worked at a time.
// No clearing pass after reset; entries read as garbage until loaded.
// While the result register is full and not taken, the sequencer holds.
module step_sequencer_with_retry (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  step_index_i,
  input  logic [3:0]  step_flags_i,
  input  logic signed [4:0] jump_target_i,
  input  logic [7:0]  retry_limit_i,
  input  logic [15:0] retry_interval_i,
  input  logic [7:0]  failed_retry_limit_i,
  input  logic [15:0] failed_retry_interval_i,
  input  logic [7:0]  fail_code_i,
  input  logic        judge_passed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [3:0]  step_number_o,
  output logic [7:0]  error_value_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssr_pkg::*;

  logic [4:0]  step_count_q;
  logic        out_valid_q;
  logic [2:0]  ev_q;
  logic [3:0]  step_q;
  logic [7:0]  err_q;
  logic        last_q;

  logic        out_free;
  logic        load_we;
  rd_t         rd;
  emit_t       emit;
  logic [$bits(ctl_t)-1:0] ctl_rdata;
  logic [$bits(tim_t)-1:0] tim_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegStepCount) ? {27'd0, step_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= 5'd1;
    end else if (psel && penable && pwrite && paddr[2] == RegStepCount) begin
      step_count_q <= pwdata[4:0];
    end
  end

  assign load_we = in_valid_i && in_ready_o && (op_e'(op_i) == OP_LOAD)
                   && ({2'b00, step_index_i} < CmpW'(MaxSteps));

  ssr_ram #(.Width($bits(ctl_t)), .Depth(MaxSteps)) u_ctl_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (StepW'(step_index_i)),
    .wdata_i ({fail_code_i, jump_target_i, step_flags_i}),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (ctl_rdata)
  );

  ssr_ram #(.Width($bits(tim_t)), .Depth(MaxSteps)) u_tim_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (StepW'(step_index_i)),
    .wdata_i ({failed_retry_interval_i, failed_retry_limit_i,
               retry_interval_i, retry_limit_i}),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (tim_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  ssr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_e'(op_i)),
    .judge_passed_i (judge_passed_i),
    .step_count_i   (step_count_q),
    .out_free_i     (out_free),
    .rd_o           (rd),
    .ctl_i          (ctl_t'(ctl_rdata)),
    .tim_i          (tim_t'(tim_rdata)),
    .emit_o         (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // action and failure action are always followed by another result
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      ev_q   <= emit.ev;
      step_q <= emit.step;
      err_q  <= emit.err;
      last_q <= (emit.ev != EV_ACTION) && (emit.ev != EV_FAIL_ACTION);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign step_number_o = step_q;
  assign error_value_o = err_q;
  assign last_o        = last_q;

  a_emit_into_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending result");

  a_no_emit_while_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> !in_ready_o)
    else $error("result produced while waiting for an item");

  a_load_single_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i == OP_LOAD) |=> in_ready_o)
    else $error("load item did not complete in one cycle");

  a_err_only_on_done_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o != EV_DONE_ERR) |-> (error_value_o == 8'd0))
    else $error("error value on a non-error result");

endmodule

@@ tb/tb_step_sequencer_with_retry.sv @@
// Testbench for step_sequencer_with_retry: directed and random items against a
// cycle-free shadow of the sequencer. Needs ssr_pkg and the RTL of the block.

typedef enum logic [2:0] {
  SEQ_IDLE,
  SEQ_WAIT_JUDGE,
  SEQ_DELAY,
  SEQ_WAIT_FJUDGE,
  SEQ_FDELAY
} seq_phase_e;

typedef struct packed {
  ssr_pkg::op_e       op;
  logic [3:0]         index;
  logic [3:0]         flags;
  logic signed [4:0]  jump;
  logic [7:0]         limit;
  logic [15:0]        interval;
  logic [7:0]         flimit;
  logic [15:0]        finterval;
  logic [7:0]         code;
  logic               passed;
} seq_item_t;

typedef struct packed {
  ssr_pkg::ev_e ev;
  logic [3:0]   step;
  logic [7:0]   err;
  logic         last;
} step_event_t;

// Shadow of the sequencer state plus the events it still owes
class step_shadow;
  ssr_pkg::ctl_t ctl_tab [ssr_pkg::MaxSteps];
  ssr_pkg::tim_t tim_tab [ssr_pkg::MaxSteps];
  logic [4:0]    count_reg;
  seq_phase_e    phase;
  logic [3:0]    cur;
  logic [7:0]    tries;
  logic [7:0]    ftries;
  logic [15:0]   delay_left;
  step_event_t   due[$];
  step_event_t   fresh[$];
  int            errors;

  function new();
    foreach (ctl_tab[i]) begin
      ctl_tab[i] = '0;
      tim_tab[i] = '0;
    end
    count_reg  = 5'd1;
    phase      = SEQ_IDLE;
    cur        = '0;
    tries      = '0;
    ftries     = '0;
    delay_left = '0;
    errors     = 0;
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function int steps_in_use();
    if (count_reg == 5'd0) return 1;
    if (int'(count_reg) > ssr_pkg::MaxSteps) return ssr_pkg::MaxSteps;
    return int'(count_reg);
  endfunction

  function void post_event(ssr_pkg::ev_e ev, logic [3:0] stp, logic [7:0] err);
    step_event_t e;
    e.ev   = ev;
    e.step = stp;
    e.err  = err;
    e.last = 1'b0;
    if (fresh.size() < ssr_pkg::MaxSteps + 2) fresh.push_back(e);
  endfunction

  // walks forward through steps without a judge
  function void enter_step(logic [3:0] first);
    logic [3:0] i;
    int         n;
    bit         stop;
    i    = first;
    n    = steps_in_use();
    stop = 1'b0;
    while (!stop) begin
      cur    = i;
      tries  = '0;
      ftries = '0;
      if (ctl_tab[i].flags[0]) post_event(ssr_pkg::EV_ACTION, i, 8'h00);
      if (ctl_tab[i].flags[1]) begin
        post_event(ssr_pkg::EV_JUDGE, i, 8'h00);
        phase = SEQ_WAIT_JUDGE;
        stop  = 1'b1;
      end else if (int'(i) + 1 < n) begin
        i = i + 1'b1;
      end else begin
        post_event(ssr_pkg::EV_DONE_OK, i, 8'h00);
        phase = SEQ_IDLE;
        stop  = 1'b1;
      end
    end
  endfunction

  function void next_step();
    if (int'(cur) + 1 < steps_in_use()) begin
      enter_step(cur + 1'b1);
    end else begin
      post_event(ssr_pkg::EV_DONE_OK, cur, 8'h00);
      phase = SEQ_IDLE;
    end
  endfunction

  // negative or out-of-range jump ends the run with the step's code
  function void abandon_step();
    logic [4:0] raw;
    raw = ctl_tab[cur].jump;
    if (!raw[4] && int'(raw) < steps_in_use()) begin
      enter_step(raw[3:0]);
    end else begin
      post_event(ssr_pkg::EV_DONE_ERR, cur, ctl_tab[cur].fail_code);
      phase = SEQ_IDLE;
    end
  endfunction

  function void handle_failure();
    if (!ctl_tab[cur].flags[2]) begin
      abandon_step();
    end else begin
      post_event(ssr_pkg::EV_FAIL_ACTION, cur, 8'h00);
      if (!ctl_tab[cur].flags[3]) begin
        next_step();
      end else begin
        post_event(ssr_pkg::EV_FAIL_JUDGE, cur, 8'h00);
        phase = SEQ_WAIT_FJUDGE;
      end
    end
  endfunction

  function void wait_over();
    if (phase == SEQ_DELAY) begin
      if (tries < 8'd255) tries = tries + 1'b1;
      if (tries >= tim_tab[cur].limit) begin
        handle_failure();
      end else begin
        post_event(ssr_pkg::EV_JUDGE, cur, 8'h00);
        phase = SEQ_WAIT_JUDGE;
      end
    end else begin
      if (ftries < 8'd255) ftries = ftries + 1'b1;
      if (ftries >= tim_tab[cur].flimit) begin
        abandon_step();
      end else begin
        post_event(ssr_pkg::EV_FAIL_JUDGE, cur, 8'h00);
        phase = SEQ_WAIT_FJUDGE;
      end
    end
  endfunction

  function void begin_wait(seq_phase_e ph, logic [15:0] ticks);
    phase      = ph;
    delay_left = ticks;
    if (delay_left == 16'd0) wait_over();
  endfunction

  function void apply_item(seq_item_t it);
    fresh.delete();
    case (it.op)
      ssr_pkg::OP_LOAD: begin
        ctl_tab[it.index].flags     = it.flags;
        ctl_tab[it.index].jump      = it.jump;
        ctl_tab[it.index].fail_code = it.code;
        tim_tab[it.index].limit     = it.limit;
        tim_tab[it.index].interval  = it.interval;
        tim_tab[it.index].flimit    = it.flimit;
        tim_tab[it.index].finterval = it.finterval;
      end
      ssr_pkg::OP_START: begin
        if (phase == SEQ_IDLE) enter_step(4'd0);
      end
      ssr_pkg::OP_ANSWER: begin
        if (phase == SEQ_WAIT_JUDGE) begin
          if (it.passed) next_step();
          else begin_wait(SEQ_DELAY, tim_tab[cur].interval);
        end else if (phase == SEQ_WAIT_FJUDGE) begin
          if (it.passed) next_step();
          else begin_wait(SEQ_FDELAY, tim_tab[cur].finterval);
        end
      end
      default: begin
        if (phase == SEQ_DELAY || phase == SEQ_FDELAY) begin
          if (delay_left != 16'd0) delay_left = delay_left - 1'b1;
          if (delay_left == 16'd0) wait_over();
        end
      end
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[k]) due.push_back(fresh[k]);
  endfunction

  function void match_event(logic [2:0] ev, logic [3:0] stp, logic [7:0] err, logic last);
    step_event_t e;
    if (due.size() == 0) begin
      report($sformatf("unexpected result: event %0d step %0d error %0d last %0d",
                       ev, stp, err, last));
      return;
    end
    e = due.pop_front();
    if (e.ev !== ev || e.step !== stp || e.err !== err || e.last !== last) begin
      report($sformatf({"result mismatch: expected event %0d step %0d error %0d last %0d,",
                        " got event %0d step %0d error %0d last %0d"},
                       e.ev, e.step, e.err, e.last, ev, stp, err, last));
    end
  endfunction
endclass

module tb_step_sequencer_with_retry;
  timeunit 1ns;
  timeprecision 1ps;

  import ssr_pkg::*;

  localparam int         StallLimit    = 3000;
  localparam int         SettleCycles  = 100;
  localparam logic [2:0] StepCountAddr = 3'(4 * int'(RegStepCount));

  localparam logic [3:0] FL_ACTION      = 4'b0001;
  localparam logic [3:0] FL_JUDGE       = 4'b0010;
  localparam logic [3:0] FL_FAIL_ACTION = 4'b0100;
  localparam logic [3:0] FL_FAIL_JUDGE  = 4'b1000;
  localparam logic signed [4:0] NO_JUMP = -5'sd1;

  logic        clk_i                   = 1'b0;
  logic        rst_ni                  = 1'b0;
  logic        in_valid_i              = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i                    = '0;
  logic [3:0]  step_index_i            = '0;
  logic [3:0]  step_flags_i            = '0;
  logic signed [4:0] jump_target_i     = '0;
  logic [7:0]  retry_limit_i           = '0;
  logic [15:0] retry_interval_i        = '0;
  logic [7:0]  failed_retry_limit_i    = '0;
  logic [15:0] failed_retry_interval_i = '0;
  logic [7:0]  fail_code_i             = '0;
  logic        judge_passed_i          = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i             = 1'b0;
  logic [2:0]  event_res_o;
  logic [3:0]  step_number_o;
  logic [7:0]  error_value_o;
  logic        last_o;
  logic        psel                    = 1'b0;
  logic        penable                 = 1'b0;
  logic        pwrite                  = 1'b0;
  logic [2:0]  paddr                   = '0;
  logic [31:0] pwdata                  = '0;
  logic [31:0] prdata;
  logic        pready;

  step_shadow sb;
  int         gap_pct   = 0;
  int         stall_pct = 0;
  int         quiet     = 0;

  step_sequencer_with_retry u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .op_i                   (op_i),
    .step_index_i           (step_index_i),
    .step_flags_i           (step_flags_i),
    .jump_target_i          (jump_target_i),
    .retry_limit_i          (retry_limit_i),
    .retry_interval_i       (retry_interval_i),
    .failed_retry_limit_i   (failed_retry_limit_i),
    .failed_retry_interval_i(failed_retry_interval_i),
    .fail_code_i            (fail_code_i),
    .judge_passed_i         (judge_passed_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .event_res_o            (event_res_o),
    .step_number_o          (step_number_o),
    .error_value_o          (error_value_o),
    .last_o                 (last_o),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.match_event(event_res_o, step_number_o, error_value_o, last_o);
    end
  end

  // counts cycles in which no item, result or register access moves
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic seq_item_t random_fields();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(seq_item_t)-1:0];
  endfunction

  function automatic seq_item_t ctrl_item(op_e op, logic passed);
    seq_item_t it;
    it        = random_fields();
    it.op     = op;
    it.passed = passed;
    return it;
  endfunction

  function automatic seq_item_t load_item(logic [3:0] idx, logic [3:0] flags,
                                          logic signed [4:0] jump, logic [7:0] limit,
                                          logic [15:0] interval, logic [7:0] flimit,
                                          logic [15:0] finterval, logic [7:0] code);
    seq_item_t it;
    it           = random_fields();
    it.op        = OP_LOAD;
    it.index     = idx;
    it.flags     = flags;
    it.jump      = jump;
    it.limit     = limit;
    it.interval  = interval;
    it.flimit    = flimit;
    it.finterval = finterval;
    it.code      = code;
    return it;
  endfunction

  // short limits and intervals mostly, so runs get through their retries
  function automatic seq_item_t random_load();
    seq_item_t it;
    int        r;
    it       = random_fields();
    it.op    = OP_LOAD;
    r        = $urandom_range(0, 9);
    if (r == 0) it.jump = NO_JUMP;
    else if (r > 1) it.jump = 5'($urandom_range(0, 15));
    it.limit  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    it.flimit = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    if (r == 1) it.interval = 16'hFFFF;
    else if (r > 1) it.interval = 16'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    if (r == 1) it.finterval = 16'hFFFF;
    else if (r > 1) it.finterval = 16'($urandom_range(0, 3));
    return it;
  endfunction

  // mostly the item the sequencer is waiting for; the rest loads and noise
  function automatic seq_item_t pick_item(output bit useful);
    seq_item_t it;
    int        r;
    it     = random_fields();
    r      = $urandom_range(0, 99);
    useful = 1'b1;
    case (sb.phase)
      SEQ_IDLE: begin
        if (r < 60) begin
          it.op = OP_START;
        end else if (r < 85) begin
          it = random_load();
        end else begin
          it.op  = r[0] ? OP_ANSWER : OP_TICK;
          useful = 1'b0;
        end
      end
      SEQ_WAIT_JUDGE, SEQ_WAIT_FJUDGE: begin
        if (r < 75) begin
          it.op = OP_ANSWER;
          // a fail with a long interval would need thousands of ticks
          if ((sb.phase == SEQ_WAIT_JUDGE && sb.tim_tab[sb.cur].interval > 16'd8) ||
              (sb.phase == SEQ_WAIT_FJUDGE && sb.tim_tab[sb.cur].finterval > 16'd8))
            it.passed = 1'b1;
        end else if (r < 85) begin
          it = random_load();
        end else begin
          it.op  = r[0] ? OP_START : OP_TICK;
          useful = 1'b0;
        end
      end
      default: begin
        if (r < 75) begin
          it.op = OP_TICK;
        end else if (r < 85) begin
          it = random_load();
        end else begin
          it.op  = r[0] ? OP_START : OP_ANSWER;
          useful = 1'b0;
        end
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input seq_item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i              <= 1'b1;
    op_i                    <= it.op;
    step_index_i            <= it.index;
    step_flags_i            <= it.flags;
    jump_target_i           <= it.jump;
    retry_limit_i           <= it.limit;
    retry_interval_i        <= it.interval;
    failed_retry_limit_i    <= it.flimit;
    failed_retry_interval_i <= it.finterval;
    fail_code_i             <= it.code;
    judge_passed_i          <= it.passed;
    do @(posedge clk_i); while (!in_ready_o);
    sb.apply_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic read_step_count();
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= StepCountAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(sb.count_reg)) begin
      sb.report($sformatf("step_count readback: expected %0d, got %0d", sb.count_reg, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits are junk; only the low five are kept
  task automatic write_step_count(input logic [4:0] count);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= StepCountAddr;
    pwdata  <= {27'($urandom), count};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.count_reg = count;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    read_step_count();
  endtask

  // answer pass or tick until the run is over
  task automatic drain();
    seq_item_t it;
    while (sb.phase != SEQ_IDLE) begin
      if (sb.phase == SEQ_WAIT_JUDGE || sb.phase == SEQ_WAIT_FJUDGE) begin
        it = ctrl_item(OP_ANSWER, 1'b1);
      end else begin
        it = ctrl_item(OP_TICK, 1'b0);
      end
      send_item(it);
    end
  endtask

  task automatic run_phase(input int gap, input int stall, input logic [4:0] count,
                           input int target, input bit fill_table);
    seq_item_t it;
    bit        useful;
    int        done_items;
    gap_pct   = gap;
    stall_pct = stall;
    write_step_count(count);
    if (fill_table) begin
      for (int k = 0; k < MaxSteps; k++) begin
        it       = random_load();
        it.index = 4'(k);
        send_item(it);
      end
    end
    done_items = 0;
    while (done_items < target) begin
      it = pick_item(useful);
      send_item(it);
      if (useful) done_items++;
    end
    drain();
    settle();
  endtask

  initial begin
    sb        = new();
    gap_pct   = 27;
    stall_pct = 50;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_step_count();

    send_item(load_item(4'd0, FL_ACTION | FL_JUDGE, NO_JUMP, 8'd1, 16'd0, 8'd0, 16'd0,
                        8'hA5));
    send_item(load_item(4'd1, FL_JUDGE | FL_FAIL_ACTION, NO_JUMP, 8'd1, 16'd1, 8'd0, 16'd0,
                        8'h00));
    send_item(load_item(4'd2, FL_JUDGE | FL_FAIL_ACTION | FL_FAIL_JUDGE, 5'sd1, 8'd2,
                        16'd1, 8'd2, 16'd0, 8'hFF));
    send_item(load_item(4'd3, FL_ACTION, 5'sd15, 8'd0, 16'd0, 8'd0, 16'd0, 8'h3C));
    send_item(load_item(4'd15, 4'hF, 5'sd15, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
    send_item(load_item(4'd14, 4'h0, 5'sd0, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00));
    // one step in use after reset: the pass ends the run
    send_item(ctrl_item(OP_START, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b1));
    settle();

    write_step_count(5'd4);
    send_item(ctrl_item(OP_TICK, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b1));
    send_item(ctrl_item(OP_START, 1'b0));
    send_item(ctrl_item(OP_START, 1'b0));
    // zero interval, no failure action, no jump: error at once
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    send_item(ctrl_item(OP_START, 1'b0));
    send_item(load_item(4'd0, FL_ACTION | FL_JUDGE, 5'sd2, 8'd1, 16'd0, 8'd0, 16'd0,
                        8'hA5));
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    send_item(ctrl_item(OP_TICK, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    send_item(ctrl_item(OP_TICK, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    send_item(ctrl_item(OP_TICK, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b1));
    settle();

    // zero counts as one step, so the jump to step 2 is out of range
    write_step_count(5'd0);
    send_item(ctrl_item(OP_START, 1'b0));
    send_item(ctrl_item(OP_ANSWER, 1'b0));
    settle();

    run_phase(27, 50, 5'd16, 80, 1'b1);
    run_phase(50, 27, 5'd31, 80, 1'b0);
    run_phase(0, 0, 5'($urandom_range(2, 15)), 80, 1'b0);

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ssr_pkg.sv
rtl/ssr_ram.sv
rtl/ssr_ctrl.sv
rtl/step_sequencer_with_retry.sv
tb/tb_step_sequencer_with_retry.sv
